FILE: src/signed_split_stream_statistics_top_defines.svh
// ----------------------------------------------------------------------------
// signed split stream statistics assertion macros
// shared concurrent assertion forms on aclk with aresetn low as disable
// ----------------------------------------------------------------------------
`ifndef SIGNED_SPLIT_STREAM_STATISTICS_TOP_DEFINES_SVH
`define SIGNED_SPLIT_STREAM_STATISTICS_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define SSSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the following cycle
`define SSSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ssss_pkg.sv
// ----------------------------------------------------------------------------
// ssss_pkg
// shared types and fixed field widths of the signed split statistics block
// ----------------------------------------------------------------------------
package ssss_pkg;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_POS  = 2'd1,
        KIND_NEG  = 2'd2
    } sample_kind_t;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 224;
    localparam int FIELD_W     = 16;
    localparam int POS_MIN_W   = 15;
    localparam int POS_SUM_W   = 31;
    localparam int NEG_SUM_W   = 32;
    localparam int MEAN_W      = 24;
    localparam int MAG_W       = 32;
    localparam int MEAN_HI     = 8388607;
    localparam int MEAN_NEG_MAG = 8388608;

    localparam logic [FIELD_W-1:0] EMPTY_MAX = 16'hFFFF;
    localparam logic [FIELD_W-1:0] EMPTY_MIN = 16'd10;

endpackage

FILE: src/ssss_front.sv
// ----------------------------------------------------------------------------
// ssss_front
// zero pads or cuts each sample and sorts it into zero, positive or negative
// ----------------------------------------------------------------------------
module ssss_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ssss_pkg::IN_TDATA_W-1:0]     s_tdata,   // sample
    input  logic                                s_tlast,   // last_sample
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [VALUE_WIDTH+2:0]              q_data
);

    logic signed [VALUE_WIDTH-1:0] value;
    ssss_pkg::sample_kind_t        kind;

    generate
        if (SAMPLE_WIDTH > ssss_pkg::IN_TDATA_W) begin : g_wide
            assign value = {1'b0, s_tdata};
        end else begin : g_narrow
            assign value = s_tdata[VALUE_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        priority if (value == '0) begin
            kind = ssss_pkg::KIND_ZERO;
        end else if (value[VALUE_WIDTH-1]) begin
            kind = ssss_pkg::KIND_NEG;
        end else begin
            kind = ssss_pkg::KIND_POS;
        end
    end

    assign q_valid  = s_tvalid;
    assign s_tready = q_ready;
    assign q_data   = {s_tlast, kind, value};

endmodule

FILE: src/ssss_queue.sv
// ----------------------------------------------------------------------------
// ssss_queue
// two entry request queue between the classifying front and the statistics back
// ----------------------------------------------------------------------------
`include "signed_split_stream_statistics_top_defines.svh"

module ssss_queue #(
    parameter int WIDTH = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int Depth = 2;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    logic [WIDTH-1:0] mem_reg [Depth];
    logic [AddrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CntW'(Depth));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? AddrW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? AddrW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `SSSS_ASSERT_SAME(a_queue_bound, 1'b1, count_reg <= CntW'(Depth), "queue overfilled")
    `SSSS_ASSERT_NEXT(a_queue_drain, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue count lost a pop")

endmodule

FILE: src/ssss_div.sv
// ----------------------------------------------------------------------------
// ssss_div
// restoring unsigned divider producing one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssss_div #(
    parameter int DIVIDEND_WIDTH = 40,
    parameter int DIVISOR_WIDTH  = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic                      done,
    output logic [DIVIDEND_WIDTH-1:0] quotient
);

    localparam int StepW = $clog2(DIVIDEND_WIDTH);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [StepW-1:0]          step_reg, step_next;
    logic [DIVIDEND_WIDTH-1:0] quo_reg, quo_next;
    logic [DIVISOR_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIVISOR_WIDTH-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    diff;
    logic                      fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIVIDEND_WIDTH-2:0], fits};
            rem_next  = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(DIVIDEND_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/ssss_back.sv
// ----------------------------------------------------------------------------
// ssss_back
// per class accumulation, end of list mean division and result register
// ----------------------------------------------------------------------------
`include "signed_split_stream_statistics_top_defines.svh"

module ssss_back #(
    parameter int VALUE_WIDTH        = 16,
    parameter int COUNT_WIDTH        = 16,
    parameter int MEAN_FRACTION_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic                                 item_last,
    input  ssss_pkg::sample_kind_t               item_kind,
    input  logic signed [VALUE_WIDTH-1:0]        item_value,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ssss_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int DivWidth = ssss_pkg::MAG_W + MEAN_FRACTION_BITS;
    localparam int MeanW    = ssss_pkg::MEAN_W;
    localparam logic [MeanW-1:0] EmptyMean = MeanW'(0) - (MeanW'(1) << MEAN_FRACTION_BITS);

    typedef enum logic [3:0] {
        ST_ACC     = 4'b0001,
        ST_DIV_POS = 4'b0010,
        ST_DIV_NEG = 4'b0100,
        ST_SEND    = 4'b1000
    } back_state_t;

    back_state_t                          state_reg, state_next;
    logic [COUNT_WIDTH-1:0]               pcnt_reg, pcnt_next;
    logic [COUNT_WIDTH-1:0]               ncnt_reg, ncnt_next;
    logic [COUNT_WIDTH-1:0]               zcnt_reg, zcnt_next;
    logic signed [VALUE_WIDTH-1:0]        pmax_reg, pmax_next;
    logic signed [VALUE_WIDTH-1:0]        pmin_reg, pmin_next;
    logic signed [VALUE_WIDTH-1:0]        nmax_reg, nmax_next;
    logic signed [VALUE_WIDTH-1:0]        nmin_reg, nmin_next;
    logic [ssss_pkg::POS_SUM_W-1:0]       ptot_reg, ptot_next;
    logic signed [ssss_pkg::NEG_SUM_W-1:0] ntot_reg, ntot_next;
    logic [MeanW-1:0]                     pmean_reg, pmean_next;
    logic [MeanW-1:0]                     nmean_reg, nmean_next;
    logic                                 div_start_reg, div_start_next;
    logic                                 m_valid_reg, m_valid_next;
    logic [ssss_pkg::OUT_TDATA_W-1:0]     m_data_reg, m_data_next;

    logic [ssss_pkg::MAG_W-1:0]           psum;
    logic signed [ssss_pkg::NEG_SUM_W:0]  nsum;
    logic [ssss_pkg::MAG_W-1:0]           pmag, nmag;
    logic [DivWidth-1:0]                  div_dividend;
    logic [COUNT_WIDTH-1:0]               div_divisor;
    logic                                 div_done;
    logic [DivWidth-1:0]                  div_quotient;
    logic [MeanW-2:0]                     pos_q;
    logic [MeanW-1:0]                     neg_q;
    logic [ssss_pkg::FIELD_W-1:0]         pmax_f, nmax_f, nmin_f;
    logic [ssss_pkg::POS_MIN_W-1:0]       pmin_f;
    logic [ssss_pkg::OUT_TDATA_W-1:0]     report;
    logic                                 out_free;

    assign psum = {1'b0, ptot_reg} + ssss_pkg::MAG_W'(item_value);
    assign nsum = (ssss_pkg::NEG_SUM_W + 1)'(ntot_reg) + (ssss_pkg::NEG_SUM_W + 1)'(item_value);
    assign pmag = ssss_pkg::MAG_W'(ptot_reg);
    assign nmag = ssss_pkg::MAG_W'(0) - ssss_pkg::MAG_W'(ntot_reg);

    assign div_dividend = (state_reg == ST_DIV_POS) ? (DivWidth'(pmag) << MEAN_FRACTION_BITS)
                                                    : (DivWidth'(nmag) << MEAN_FRACTION_BITS);
    assign div_divisor  = (state_reg == ST_DIV_POS) ? pcnt_reg : ncnt_reg;

    ssss_div #(
        .DIVIDEND_WIDTH(DivWidth),
        .DIVISOR_WIDTH (COUNT_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quotient)
    );

    assign pos_q = (div_quotient > DivWidth'(ssss_pkg::MEAN_HI)) ? '1 : div_quotient[MeanW-2:0];
    assign neg_q = (div_quotient > DivWidth'(ssss_pkg::MEAN_NEG_MAG)) ?
                   MeanW'(ssss_pkg::MEAN_NEG_MAG) : div_quotient[MeanW-1:0];

    // empty classes report fixed markers
    assign pmax_f = (pcnt_reg == '0) ? ssss_pkg::EMPTY_MAX : ssss_pkg::FIELD_W'(pmax_reg);
    assign pmin_f = (pcnt_reg == '0) ? ssss_pkg::POS_MIN_W'(ssss_pkg::EMPTY_MIN)
                                     : ssss_pkg::POS_MIN_W'(pmin_reg);
    assign nmax_f = (ncnt_reg == '0) ? ssss_pkg::EMPTY_MAX : ssss_pkg::FIELD_W'(nmax_reg);
    assign nmin_f = (ncnt_reg == '0) ? ssss_pkg::EMPTY_MIN : ssss_pkg::FIELD_W'(nmin_reg);

    assign report = {2'b00,
                     ssss_pkg::FIELD_W'(zcnt_reg),
                     nmean_reg,
                     ntot_reg,
                     nmin_f,
                     nmax_f,
                     ssss_pkg::FIELD_W'(ncnt_reg),
                     pmean_reg,
                     ptot_reg,
                     pmin_f,
                     pmax_f,
                     ssss_pkg::FIELD_W'(pcnt_reg)};

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        pcnt_next      = pcnt_reg;
        ncnt_next      = ncnt_reg;
        zcnt_next      = zcnt_reg;
        pmax_next      = pmax_reg;
        pmin_next      = pmin_reg;
        nmax_next      = nmax_reg;
        nmin_next      = nmin_reg;
        ptot_next      = ptot_reg;
        ntot_next      = ntot_reg;
        pmean_next     = pmean_reg;
        nmean_next     = nmean_reg;
        div_start_next = 1'b0;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        unique case (state_reg)
            ST_ACC: begin
                if (item_valid) begin
                    unique case (item_kind)
                        ssss_pkg::KIND_ZERO: begin
                            if (zcnt_reg != '1) begin
                                zcnt_next = zcnt_reg + 1'b1;
                            end
                        end
                        ssss_pkg::KIND_POS: begin
                            if (pcnt_reg == '0) begin
                                pmax_next = item_value;
                                pmin_next = item_value;
                            end else begin
                                if (item_value > pmax_reg) begin
                                    pmax_next = item_value;
                                end
                                if (item_value < pmin_reg) begin
                                    pmin_next = item_value;
                                end
                            end
                            if (pcnt_reg != '1) begin
                                pcnt_next = pcnt_reg + 1'b1;
                            end
                            ptot_next = psum[ssss_pkg::MAG_W-1] ? '1
                                                                : psum[ssss_pkg::POS_SUM_W-1:0];
                        end
                        ssss_pkg::KIND_NEG: begin
                            if (ncnt_reg == '0) begin
                                nmax_next = item_value;
                                nmin_next = item_value;
                            end else begin
                                if (item_value > nmax_reg) begin
                                    nmax_next = item_value;
                                end
                                if (item_value < nmin_reg) begin
                                    nmin_next = item_value;
                                end
                            end
                            if (ncnt_reg != '1) begin
                                ncnt_next = ncnt_reg + 1'b1;
                            end
                            if (nsum[ssss_pkg::NEG_SUM_W] != nsum[ssss_pkg::NEG_SUM_W-1]) begin
                                ntot_next = {1'b1, {(ssss_pkg::NEG_SUM_W-1){1'b0}}};
                            end else begin
                                ntot_next = nsum[ssss_pkg::NEG_SUM_W-1:0];
                            end
                        end
                        default: begin
                            zcnt_next = zcnt_reg;
                        end
                    endcase
                    if (item_last) begin
                        state_next     = ST_DIV_POS;
                        div_start_next = 1'b1;
                    end
                end
            end
            ST_DIV_POS: begin
                if (div_done) begin
                    pmean_next     = (pcnt_reg == '0) ? EmptyMean : {1'b0, pos_q};
                    div_start_next = 1'b1;
                    state_next     = ST_DIV_NEG;
                end
            end
            ST_DIV_NEG: begin
                if (div_done) begin
                    nmean_next = (ncnt_reg == '0) ? EmptyMean : MeanW'(0) - neg_q;
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = report;
                    pcnt_next    = '0;
                    ncnt_next    = '0;
                    zcnt_next    = '0;
                    ptot_next    = '0;
                    ntot_next    = '0;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            pcnt_reg      <= '0;
            ncnt_reg      <= '0;
            zcnt_reg      <= '0;
            ptot_reg      <= '0;
            ntot_reg      <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pcnt_reg      <= pcnt_next;
            ncnt_reg      <= ncnt_next;
            zcnt_reg      <= zcnt_next;
            ptot_reg      <= ptot_next;
            ntot_reg      <= ntot_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pmax_reg   <= pmax_next;
        pmin_reg   <= pmin_next;
        nmax_reg   <= nmax_next;
        nmin_reg   <= nmin_next;
        pmean_reg  <= pmean_next;
        nmean_reg  <= nmean_next;
        m_data_reg <= m_data_next;
    end

    assign item_ready = (state_reg == ST_ACC);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    `SSSS_ASSERT_NEXT(a_last_starts_div, state_reg == ST_ACC && item_valid && item_last, state_reg == ST_DIV_POS && div_start_reg, "last request did not start division")
    `SSSS_ASSERT_SAME(a_done_in_div, div_done, state_reg == ST_DIV_POS || state_reg == ST_DIV_NEG, "divider finished outside a mean state")
    `SSSS_ASSERT_NEXT(a_send_clears, state_reg == ST_SEND && out_free, m_valid_reg && pcnt_reg == '0 && ncnt_reg == '0 && zcnt_reg == '0 && state_reg == ST_ACC, "report did not clear statistics")

endmodule

FILE: src/signed_split_stream_statistics_top.sv
// ----------------------------------------------------------------------------
// signed_split_stream_statistics_top
// running count, max, min, sum and mean of positive and negative samples
// ----------------------------------------------------------------------------
// samples are taken at one per clock while a list accumulates; the sample
// flagged tlast closes the list and one report request leaves on m_ after the
// two class means pass through a shared one bit per cycle divider; a two
// entry queue keeps s_tready high during that work until it fills, and
// the result register lets the next list accumulate while a report waits
module signed_split_stream_statistics_top #(
    parameter int SAMPLE_WIDTH       = 16,
    parameter int COUNT_WIDTH        = 16,
    parameter int MEAN_FRACTION_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ssss_pkg::IN_TDATA_W-1:0]     s_tdata,   // sample
    input  logic                                s_tlast,   // last_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pos_count, pos_max, pos_min, pos_sum, pos_mean, neg_count, neg_max,
    // neg_min, neg_sum, neg_mean, zero_count, zero pad
    output logic [ssss_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int ValueWidth = (SAMPLE_WIDTH > ssss_pkg::IN_TDATA_W) ?
                                ssss_pkg::IN_TDATA_W + 1 : SAMPLE_WIDTH;
    localparam int ItemWidth  = ValueWidth + 3;

    logic                 fq_valid, fq_ready;
    logic [ItemWidth-1:0] fq_data;
    logic                 qb_valid, qb_ready;
    logic [ItemWidth-1:0] qb_data;

    ssss_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .VALUE_WIDTH (ValueWidth)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    ssss_queue #(
        .WIDTH(ItemWidth)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    ssss_back #(
        .VALUE_WIDTH       (ValueWidth),
        .COUNT_WIDTH       (COUNT_WIDTH),
        .MEAN_FRACTION_BITS(MEAN_FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(qb_valid),
        .item_ready(qb_ready),
        .item_last (qb_data[ItemWidth-1]),
        .item_kind (ssss_pkg::sample_kind_t'(qb_data[ValueWidth+1:ValueWidth])),
        .item_value(qb_data[ValueWidth-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: dv/tb_signed_split_stream_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_split_stream_statistics_top
// self-checking bench for the signed split stream statistics block
// ----------------------------------------------------------------------------
// sample lists go in on s_, each report leaving on m_ is compared field by
// field against an in-bench model of the class statistics; a directed table
// covers empty classes, extremes and mean truncation, one long list of near
// extreme samples follows, and random lists run under four idle and stall
// mixes on both sides
// ----------------------------------------------------------------------------
module tb_signed_split_stream_statistics_top;

    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_TRIPLES = 100;

    // fields from the lowest bit up: pos_count first, two pad bits on top
    typedef struct packed {
        logic [1:0]                             pad;
        logic [ssss_pkg::FIELD_W-1:0]           zero_count;
        logic signed [ssss_pkg::MEAN_W-1:0]     neg_mean;
        logic signed [ssss_pkg::NEG_SUM_W-1:0]  neg_sum;
        logic signed [ssss_pkg::FIELD_W-1:0]    neg_min;
        logic signed [ssss_pkg::FIELD_W-1:0]    neg_max;
        logic [ssss_pkg::FIELD_W-1:0]           neg_count;
        logic signed [ssss_pkg::MEAN_W-1:0]     pos_mean;
        logic [ssss_pkg::POS_SUM_W-1:0]         pos_sum;
        logic [ssss_pkg::POS_MIN_W-1:0]         pos_min;
        logic signed [ssss_pkg::FIELD_W-1:0]    pos_max;
        logic [ssss_pkg::FIELD_W-1:0]           pos_count;
    } stats_report_t;

    typedef struct {
        logic signed [ssss_pkg::FIELD_W-1:0] sample;
        bit                                  last;
        bit                                  typed;
        stats_report_t                       report;
    } directed_row_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ssss_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // sample
    logic                             s_tlast  = 1'b0; // last_sample
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // pos_count, pos_max, pos_min, pos_sum, pos_mean, neg_count, neg_max,
    // neg_min, neg_sum, neg_mean, zero_count, zero pad
    logic [ssss_pkg::OUT_TDATA_W-1:0] m_tdata;

    signed_split_stream_statistics_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // running class statistics of the list in progress
    logic [ssss_pkg::FIELD_W-1:0]        pos_cnt, neg_cnt, zero_cnt;
    logic signed [ssss_pkg::FIELD_W-1:0] pos_hi, pos_lo, neg_hi, neg_lo;
    longint                              pos_tot, neg_tot;

    stats_report_t pending_reports[$];
    directed_row_t directed_rows[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int reports_seen = 0;
    int samples_sent = 0;
    int lists_sent = 0;
    int longest_list = 0;
    int list_len = 0;
    int quiet_cycles = 0;

    function automatic stats_report_t empty_report();
        stats_report_t r;
        r = '0;
        r.pos_max  = ssss_pkg::EMPTY_MAX;
        r.pos_min  = ssss_pkg::EMPTY_MIN[ssss_pkg::POS_MIN_W-1:0];
        r.pos_mean = -24'sd256;
        r.neg_max  = ssss_pkg::EMPTY_MAX;
        r.neg_min  = ssss_pkg::EMPTY_MIN;
        r.neg_mean = -24'sd256;
        return r;
    endfunction

    task automatic clear_stats();
        pos_cnt  = '0;
        neg_cnt  = '0;
        zero_cnt = '0;
        pos_hi   = ssss_pkg::EMPTY_MAX;
        pos_lo   = ssss_pkg::EMPTY_MIN;
        neg_hi   = ssss_pkg::EMPTY_MAX;
        neg_lo   = ssss_pkg::EMPTY_MIN;
        pos_tot  = 0;
        neg_tot  = 0;
    endtask

    function automatic logic signed [ssss_pkg::MEAN_W-1:0] class_mean(
        longint total, logic [ssss_pkg::FIELD_W-1:0] cnt);
        longint mag, q, r;
        if (cnt == 0) return -24'sd256;
        mag = (total < 0) ? -total : total;
        q = (mag << 8) / longint'(cnt);
        if (q > longint'(ssss_pkg::MEAN_HI) + 1) q = longint'(ssss_pkg::MEAN_HI) + 1;
        r = (total < 0) ? -q : q;
        if (r > longint'(ssss_pkg::MEAN_HI)) r = ssss_pkg::MEAN_HI;
        if (r < -longint'(ssss_pkg::MEAN_NEG_MAG)) r = -longint'(ssss_pkg::MEAN_NEG_MAG);
        return r[ssss_pkg::MEAN_W-1:0];
    endfunction

    task automatic absorb_sample(input logic signed [ssss_pkg::FIELD_W-1:0] s,
                                 input bit last,
                                 output bit done, output stats_report_t rep);
        done = 1'b0;
        rep  = '0;
        if (s == 0) begin
            if (zero_cnt != '1) zero_cnt++;
        end else if (s > 0) begin
            if (pos_cnt == 0) begin
                pos_hi = s;
                pos_lo = s;
            end else begin
                if (s > pos_hi) pos_hi = s;
                if (s < pos_lo) pos_lo = s;
            end
            if (pos_cnt != '1) pos_cnt++;
            pos_tot += s;
            if (pos_tot > 64'sd2147483647) pos_tot = 64'sd2147483647;
        end else begin
            if (neg_cnt == 0) begin
                neg_hi = s;
                neg_lo = s;
            end else begin
                if (s > neg_hi) neg_hi = s;
                if (s < neg_lo) neg_lo = s;
            end
            if (neg_cnt != '1) neg_cnt++;
            neg_tot += s;
            if (neg_tot < -64'sd2147483648) neg_tot = -64'sd2147483648;
        end
        if (last) begin
            done           = 1'b1;
            rep.pos_count  = pos_cnt;
            rep.pos_max    = pos_hi;
            rep.pos_min    = pos_lo[ssss_pkg::POS_MIN_W-1:0];
            rep.pos_sum    = pos_tot[ssss_pkg::POS_SUM_W-1:0];
            rep.pos_mean   = class_mean(pos_tot, pos_cnt);
            rep.neg_count  = neg_cnt;
            rep.neg_max    = neg_hi;
            rep.neg_min    = neg_lo;
            rep.neg_sum    = neg_tot[ssss_pkg::NEG_SUM_W-1:0];
            rep.neg_mean   = class_mean(neg_tot, neg_cnt);
            rep.zero_count = zero_cnt;
            clear_stats();
        end
    endtask

    // one request on s_, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [ssss_pkg::FIELD_W-1:0] s,
                               input bit last,
                               input bit typed = 1'b0,
                               input stats_report_t typed_rep = '0);
        bit            done;
        stats_report_t rep;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        absorb_sample(s, last, done, rep);
        if (done) pending_reports.push_back(typed ? typed_rep : rep);
        samples_sent++;
        list_len++;
        if (last) begin
            lists_sent++;
            if (list_len > longest_list) longest_list = list_len;
            list_len = 0;
        end
    endtask

    function automatic logic signed [ssss_pkg::FIELD_W-1:0] random_sample();
        case ($urandom_range(9))
            0: return 16'sd0;
            1: return 16'sd32767;
            2: return -16'sd32768;
            3: return 16'($urandom_range(16, 1));
            4: return -16'($urandom_range(16, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic flag_field(input string what, input longint e, input longint a);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %0d, got %0d", what, e, a);
    endtask

    task automatic compare_report(input stats_report_t e, input stats_report_t a);
        if (e.pos_count !== a.pos_count) flag_field("pos_count", e.pos_count, a.pos_count);
        if (e.pos_max !== a.pos_max) flag_field("pos_max", e.pos_max, a.pos_max);
        if (e.pos_min !== a.pos_min) flag_field("pos_min", e.pos_min, a.pos_min);
        if (e.pos_sum !== a.pos_sum) flag_field("pos_sum", e.pos_sum, a.pos_sum);
        if (e.pos_mean !== a.pos_mean) flag_field("pos_mean", e.pos_mean, a.pos_mean);
        if (e.neg_count !== a.neg_count) flag_field("neg_count", e.neg_count, a.neg_count);
        if (e.neg_max !== a.neg_max) flag_field("neg_max", e.neg_max, a.neg_max);
        if (e.neg_min !== a.neg_min) flag_field("neg_min", e.neg_min, a.neg_min);
        if (e.neg_sum !== a.neg_sum) flag_field("neg_sum", e.neg_sum, a.neg_sum);
        if (e.neg_mean !== a.neg_mean) flag_field("neg_mean", e.neg_mean, a.neg_mean);
        if (e.zero_count !== a.zero_count)
            flag_field("zero_count", e.zero_count, a.zero_count);
        if (a.pad !== 2'b00) flag_field("pad", 0, a.pad);
    endtask

    // result side: random stalls, checking and the quiet-cycle watchdog
    always @(posedge aclk) begin
        stats_report_t got;
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected report request");
                end else begin
                    compare_report(pending_reports.pop_front(), got);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        stats_report_t r;
        int count;
        int len;

        clear_stats();

        r = empty_report();
        r.zero_count = 1;
        directed_rows.push_back('{16'sd0, 1'b1, 1'b1, r});
        r = empty_report();
        r.pos_count = 1; r.pos_max = 32767; r.pos_min = 32767;
        r.pos_sum = 32767; r.pos_mean = 24'sd8388352;
        directed_rows.push_back('{16'sd32767, 1'b1, 1'b1, r});
        r = empty_report();
        r.neg_count = 1; r.neg_max = -32768; r.neg_min = -32768;
        r.neg_sum = -32768; r.neg_mean = -24'sd8388608;
        directed_rows.push_back('{-16'sd32768, 1'b1, 1'b1, r});
        r = empty_report();
        r.pos_count = 1; r.pos_max = 1; r.pos_min = 1; r.pos_sum = 1; r.pos_mean = 256;
        directed_rows.push_back('{16'sd1, 1'b1, 1'b1, r});
        r = empty_report();
        r.neg_count = 1; r.neg_max = -1; r.neg_min = -1; r.neg_sum = -1; r.neg_mean = -256;
        directed_rows.push_back('{-16'sd1, 1'b1, 1'b1, r});
        // mixed list with means that truncate toward zero
        directed_rows.push_back('{16'sd5, 1'b0, 1'b0, '0});
        directed_rows.push_back('{-16'sd7, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sd0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sd3, 1'b0, 1'b0, '0});
        directed_rows.push_back('{-16'sd2, 1'b0, 1'b0, '0});
        directed_rows.push_back('{-16'sd4, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sd9, 1'b1, 1'b0, '0});
        // alternating bit patterns and near extremes
        directed_rows.push_back('{16'sh5555, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'shAAAA, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sh7FFE, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sh8001, 1'b1, 1'b0, '0});
        // zeros only
        directed_rows.push_back('{16'sd0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sd0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sd0, 1'b1, 1'b0, '0});
        // both classes hit both extremes
        directed_rows.push_back('{16'sd100, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sd32767, 1'b0, 1'b0, '0});
        directed_rows.push_back('{16'sd1, 1'b0, 1'b0, '0});
        directed_rows.push_back('{-16'sd1, 1'b0, 1'b0, '0});
        directed_rows.push_back('{-16'sd32768, 1'b1, 1'b0, '0});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_sample(directed_rows[i].sample, directed_rows[i].last,
                        directed_rows[i].typed, directed_rows[i].report);

        // one long list of near extreme samples in all three classes
        for (int i = 0; i < LONG_TRIPLES; i++) begin
            send_sample(16'(32000 + $urandom_range(767)), 1'b0);
            send_sample(($urandom_range(3) != 0) ? -16'sd32768
                        : -16'(32000 + $urandom_range(767)), 1'b0);
            send_sample(16'sd0, 1'b0);
        end
        send_sample(-16'sd32768, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            count = 0;
            while (count < RANDOM_ITEMS) begin
                case ($urandom_range(9))
                    0: len = 1;
                    1: len = $urandom_range(120, 30);
                    default: len = $urandom_range(12, 2);
                endcase
                for (int k = 0; k < len; k++)
                    send_sample(random_sample(), k == len - 1);
                count += len;
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (pending_reports.size() != 0) begin
            $display("%0d report(s) never arrived", pending_reports.size());
            mismatches += pending_reports.size();
        end
        $display("%0d samples in %0d lists sent, %0d reports checked, longest list %0d",
                 samples_sent, lists_sent, reports_seen, longest_list);
        $display("long list of %0d near extreme samples, four idle/stall mixes, %0d mismatches",
                 3 * LONG_TRIPLES + 1, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
